### rtl/szd_pkg.sv
// Shared types and constants for the SZDD/LZSS decoder.
// Used by the controller, the datapath and the top level; depends on nothing.
package szd_pkg;

	typedef enum logic [1:0] {
		KIND_DATA    = 2'd0,
		KIND_HDR_OK  = 2'd1,
		KIND_HDR_BAD = 2'd2
	} kind_t;

	localparam logic [3:0] MAGIC_LEN  = 4'd9;
	localparam logic [3:0] LEN_FIRST  = 4'd10;
	localparam logic [3:0] HDR_LAST   = 4'd13;
	localparam logic [3:0] FLAG_COUNT = 4'd8;
	localparam logic [4:0] MATCH_MIN  = 5'd3;
	localparam logic [7:0] SPACE_CHAR = 8'h20;
	localparam int         WP_BACK    = 16;

	typedef struct packed {
		logic       load_in;
		logic       clear;
		logic       acc_len;
		logic [1:0] acc_idx;
		logic       load_flags;
		logic       shift_flag;
		logic       load_match_lo;
		logic       start_copy;
		logic       rd;
		logic       wr_copy;
		logic       emit_lit;
		logic       emit_hdr_ok;
		logic       emit_hdr_bad;
	} cmd_t;

	typedef struct packed {
		logic [7:0] byte_q;
		logic       flag_bit;
		logic       copy_last;
		logic       out_free;
	} sts_t;

	function automatic logic [7:0] magic_byte(input logic [3:0] idx);
		logic [7:0] b;
		case (idx)
			4'd0: b = 8'h53;
			4'd1: b = 8'h5A;
			4'd2: b = 8'h44;
			4'd3: b = 8'h44;
			4'd4: b = 8'h88;
			4'd5: b = 8'hF0;
			4'd6: b = 8'h27;
			4'd7: b = 8'h33;
			4'd8: b = 8'h41;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

### rtl/szd_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Stand-alone; no package needed.
module szd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### rtl/szd_datapath.sv
// Datapath of the decoder: input byte, flag shifter, length accumulator,
// copy pointers, history window RAM and output register. Uses szd_pkg and szd_ram.
module szd_datapath #(
	parameter int WINDOW_SIZE = 4096
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [7:0]   in_byte,
	input  szd_pkg::cmd_t cmd,
	output szd_pkg::sts_t sts,
	input  logic         out_ready,
	output logic         out_valid,
	output logic [1:0]   out_kind,
	output logic [7:0]   out_byte,
	output logic [31:0]  out_len,
	output logic         out_last
);
	import szd_pkg::*;

	localparam int AW = $clog2(WINDOW_SIZE);
	localparam int FW = AW + 1;
	localparam logic [AW-1:0] WP_START = AW'(WINDOW_SIZE - WP_BACK);
	localparam logic [FW-1:0] FILL_MAX = FW'(WINDOW_SIZE);

	logic [7:0]    byte_q;
	logic [7:0]    flag_q;
	logic [31:0]   len_q;
	logic [7:0]    match_lo_q;
	logic [AW-1:0] pos_q;
	logic [AW-1:0] wp_q;
	logic [FW-1:0] fill_q;
	logic [4:0]    cnt_q;
	logic          hit_q;
	logic          out_valid_q;
	logic [1:0]    out_kind_q;
	logic [7:0]    out_byte_q;
	logic [31:0]   out_len_q;
	logic          out_last_q;

	logic [31:0]   len_next;
	logic [11:0]   pos_raw;
	logic [AW-1:0] rd_off;
	logic          rd_hit;
	logic [7:0]    rd_data;
	logic [7:0]    copy_data;
	logic          wr_en;
	logic [7:0]    wr_data;
	logic          out_free;

	assign len_next  = len_q | (32'(byte_q) << {cmd.acc_idx, 3'b000});
	assign pos_raw   = {byte_q[7:4], match_lo_q};
	assign rd_off    = pos_q - WP_START;
	assign rd_hit    = {1'b0, rd_off} < fill_q;
	assign copy_data = hit_q ? rd_data : SPACE_CHAR;
	assign wr_en     = cmd.wr_copy | cmd.emit_lit;
	assign wr_data   = cmd.emit_lit ? byte_q : copy_data;
	assign out_free  = !out_valid_q || out_ready;

	szd_ram #(
		.WIDTH(8),
		.DEPTH(WINDOW_SIZE)
	) u_window (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wp_q),
		.wr_data (wr_data),
		.rd_en   (cmd.rd),
		.rd_addr (pos_q),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			byte_q <= in_byte;
		end
		if (cmd.load_match_lo) begin
			match_lo_q <= byte_q;
		end
		if (cmd.start_copy) begin
			pos_q <= pos_raw[AW-1:0];
			cnt_q <= 5'(byte_q[3:0]) + MATCH_MIN;
		end else if (cmd.wr_copy) begin
			pos_q <= pos_q + AW'(1);
			cnt_q <= cnt_q - 5'd1;
		end
		if (cmd.rd) begin
			hit_q <= rd_hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= 8'd0;
			len_q  <= 32'd0;
			wp_q   <= WP_START;
			fill_q <= '0;
		end else if (cmd.clear) begin
			flag_q <= 8'd0;
			len_q  <= 32'd0;
			wp_q   <= WP_START;
			fill_q <= '0;
		end else begin
			if (cmd.load_flags) begin
				flag_q <= byte_q;
			end else if (cmd.shift_flag) begin
				flag_q <= flag_q >> 1;
			end
			if (cmd.acc_len) begin
				len_q <= len_next;
			end
			if (wr_en) begin
				wp_q <= wp_q + AW'(1);
				if (fill_q != FILL_MAX) begin
					fill_q <= fill_q + FW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_lit || cmd.wr_copy || cmd.emit_hdr_ok || cmd.emit_hdr_bad) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_lit || cmd.wr_copy) begin
			out_kind_q <= KIND_DATA;
			out_byte_q <= wr_data;
			out_len_q  <= 32'd0;
			out_last_q <= cmd.emit_lit || (cnt_q == 5'd1);
		end else if (cmd.emit_hdr_ok) begin
			out_kind_q <= KIND_HDR_OK;
			out_byte_q <= 8'd0;
			out_len_q  <= len_next;
			out_last_q <= 1'b1;
		end else if (cmd.emit_hdr_bad) begin
			out_kind_q <= KIND_HDR_BAD;
			out_byte_q <= 8'd0;
			out_len_q  <= 32'd0;
			out_last_q <= 1'b1;
		end
	end

	assign sts.byte_q    = byte_q;
	assign sts.flag_bit  = flag_q[0];
	assign sts.copy_last = (cnt_q == 5'd1);
	assign sts.out_free  = out_free;

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_byte  = out_byte_q;
	assign out_len   = out_len_q;
	assign out_last  = out_last_q;

endmodule

### rtl/szd_ctrl.sv
// Controller of the decoder: input handshake, header and token parsing,
// and match copy sequencing. Uses szd_pkg; drives the datapath by commands.
module szd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_start,
	output logic          in_ready,
	input  szd_pkg::sts_t sts,
	output szd_pkg::cmd_t cmd
);
	import szd_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DECODE,
		S_READ,
		S_WRITE
	} state_t;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_DATA,
		PH_MATCH_HI,
		PH_REJECTED
	} phase_t;

	state_t     state_q, state_d;
	phase_t     phase_q, phase_d;
	logic [3:0] hc_q, hc_d;
	logic [3:0] flags_left_q, flags_left_d;
	logic       accept;

	assign accept   = in_valid && (state_q == S_IDLE);
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd          = '0;
		state_d      = state_q;
		phase_d      = phase_q;
		hc_d         = hc_q;
		flags_left_d = flags_left_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.load_in = 1'b1;
					state_d     = S_DECODE;
					if (in_start) begin
						cmd.clear    = 1'b1;
						phase_d      = PH_HEADER;
						hc_d         = 4'd0;
						flags_left_d = 4'd0;
					end
				end
			end
			S_DECODE: begin
				if (sts.out_free) begin
					state_d = S_IDLE;
					unique case (phase_q)
						PH_HEADER: begin
							if (hc_q < MAGIC_LEN && sts.byte_q != magic_byte(hc_q)) begin
								cmd.emit_hdr_bad = 1'b1;
								phase_d          = PH_REJECTED;
							end else begin
								if (hc_q >= LEN_FIRST) begin
									cmd.acc_len = 1'b1;
									cmd.acc_idx = 2'(hc_q - LEN_FIRST);
								end
								hc_d = hc_q + 4'd1;
								if (hc_q == HDR_LAST) begin
									cmd.emit_hdr_ok = 1'b1;
									phase_d         = PH_DATA;
									flags_left_d    = 4'd0;
								end
							end
						end
						PH_DATA: begin
							if (flags_left_q == 4'd0) begin
								cmd.load_flags = 1'b1;
								flags_left_d   = FLAG_COUNT;
							end else if (sts.flag_bit) begin
								cmd.emit_lit   = 1'b1;
								cmd.shift_flag = 1'b1;
								flags_left_d   = flags_left_q - 4'd1;
							end else begin
								cmd.load_match_lo = 1'b1;
								phase_d           = PH_MATCH_HI;
							end
						end
						PH_MATCH_HI: begin
							cmd.start_copy = 1'b1;
							state_d        = S_READ;
						end
						PH_REJECTED: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_READ: begin
				cmd.rd  = 1'b1;
				state_d = S_WRITE;
			end
			S_WRITE: begin
				if (sts.out_free) begin
					cmd.wr_copy = 1'b1;
					if (sts.copy_last) begin
						cmd.shift_flag = 1'b1;
						flags_left_d   = flags_left_q - 4'd1;
						phase_d        = PH_DATA;
						state_d        = S_IDLE;
					end else begin
						state_d = S_READ;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			phase_q      <= PH_HEADER;
			hc_q         <= 4'd0;
			flags_left_q <= 4'd0;
		end else begin
			state_q      <= state_d;
			phase_q      <= phase_d;
			hc_q         <= hc_d;
			flags_left_q <= flags_left_d;
		end
	end

endmodule

### rtl/szdd_lzss_decoder_top.sv
// SZDD/LZSS decoder top level. Header, control, literal and match-head bytes pass
// through an accept state and a decode state; a match byte adds a read state and
// a write state per copied byte, as the window RAM read is registered ahead of
// each write. Output waits stretch these steps. Reset and stream start clear the
// parser at once; the window needs no clearing pass, as a fill count marks unwritten
// entries. Depends on szd_pkg, szd_ctrl, szd_datapath and szd_ram.
module szdd_lzss_decoder_top #(
	parameter int WINDOW_SIZE = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic [0:0]  s_tuser,   // [0] stream_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [7:0] out_byte, [39:8] total_length
	output logic [1:0]  m_tuser,   // [1:0] kind
	output logic        m_tlast
);
	import szd_pkg::*;

	cmd_t cmd;
	sts_t sts;

	szd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_start (s_tuser[0]),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	szd_datapath #(
		.WINDOW_SIZE(WINDOW_SIZE)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_byte   (s_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_kind  (m_tuser),
		.out_byte  (m_tdata[7:0]),
		.out_len   (m_tdata[39:8]),
		.out_last  (m_tlast)
	);

	a_emit_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_lit || cmd.wr_copy || cmd.emit_hdr_ok || cmd.emit_hdr_bad) |-> sts.out_free)
		else $error("result emitted while output register is occupied");

	a_single_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.emit_lit, cmd.wr_copy, cmd.emit_hdr_ok, cmd.emit_hdr_bad}))
		else $error("more than one result emitted in one cycle");

	a_copy_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_copy |-> $past(cmd.rd) || $past(cmd.wr_copy) == 1'b0)
		else $error("copy write without a preceding window read");

	a_header_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != KIND_DATA) |-> (m_tlast && m_tdata[7:0] == 8'd0))
		else $error("header result not marked last or carries data");

endmodule

### tb/sv/tb.sv
// Self-checking testbench for szdd_lzss_decoder_top: feeds compressed SZDD files
// and checks every decoded transfer against a behavioral decoder kept in this file.
// Depends on szd_pkg and the decoder RTL.
`timescale 1ns / 100ps

module tb;
	import szd_pkg::*;

	localparam logic [71:0] SZDD_SIG = {8'h41, 8'h33, 8'h27, 8'hF0, 8'h88,
	                                    8'h44, 8'h44, 8'h5A, 8'h53};
	localparam int          SIG_BYTES  = 9;
	localparam int          LEN_AT     = 10;
	localparam int          HDR_BYTES  = 14;
	localparam int          HIST_DEPTH = 4096;
	localparam logic [11:0] HIST_BASE  = 12'hFF0;
	localparam int          QUIET_LIMIT = 3000;
	localparam int          RX_HOLD    = 300;

	typedef enum logic [1:0] {
		SCAN_HEADER,
		SCAN_TOKENS,
		SCAN_MATCH_HI,
		SCAN_REJECTED
	} scan_t;

	typedef struct packed {
		logic [7:0] data;
		logic       first;
		logic       drain;
	} comp_item_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  value;
		logic [31:0] length;
		logic        last;
	} decoded_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;   // [7:0] in_byte
	logic [0:0]  s_tuser = '0;   // [0] stream_start
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;        // [7:0] out_byte, [39:8] total_length
	logic [1:0]  m_tuser;        // [1:0] kind
	logic        m_tlast;

	comp_item_t compressed_q[$];
	decoded_t   decoded_fifo[$];

	// Decoder state mirrored by the predictor.
	logic [7:0]  hist [0:HIST_DEPTH-1];
	logic [11:0] hist_wp;
	logic [7:0]  flag_bits;
	int          flags_left;
	scan_t       scan;
	int          hdr_cnt;
	logic [31:0] hdr_len;
	logic [7:0]  match_lo;

	// Generator view of the window pointer, used to aim matches at recent output.
	logic [11:0] gen_wp;
	int          gen_out;
	int          n_live;

	int          n_pred;
	int          n_fed;
	int          n_checked;
	int          n_errors;
	int          tx_gap;
	int          rx_gap;
	int          hold_left;
	bit          hold_done;
	bit          tx_steady;
	bit          rx_steady;
	int          quiet_cycles;
	decoded_t    want;

	szdd_lzss_decoder_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void restart_decoder();
		for (int i = 0; i < HIST_DEPTH; i++)
			hist[i] = SPACE_CHAR;
		hist_wp = HIST_BASE;
		flag_bits = '0;
		flags_left = 0;
		scan = SCAN_HEADER;
		hdr_cnt = 0;
		hdr_len = '0;
		match_lo = '0;
	endfunction

	function automatic void push_result(input kind_t k, input logic [7:0] v,
	                                    input logic [31:0] l, input logic last);
		decoded_t r;
		r.kind = k;
		r.value = v;
		r.length = l;
		r.last = last;
		decoded_fifo.push_back(r);
		n_pred++;
	endfunction

	function automatic void hist_put(input logic [7:0] v);
		hist[hist_wp] = v;
		hist_wp = hist_wp + 12'd1;
	endfunction

	function automatic void decode_byte(input logic [7:0] b, input logic first);
		logic [11:0] pos;
		logic [7:0]  v;
		int          cnt;
		if (first)
			restart_decoder();
		case (scan)
			SCAN_HEADER: begin
				if (hdr_cnt < SIG_BYTES && b != SZDD_SIG[8*hdr_cnt +: 8]) begin
					push_result(KIND_HDR_BAD, 8'h00, 32'h0, 1'b1);
					scan = SCAN_REJECTED;
				end else begin
					if (hdr_cnt >= LEN_AT)
						hdr_len[8*(hdr_cnt-LEN_AT) +: 8] = b;
					hdr_cnt++;
					if (hdr_cnt == HDR_BYTES) begin
						push_result(KIND_HDR_OK, 8'h00, hdr_len, 1'b1);
						scan = SCAN_TOKENS;
						flags_left = 0;
						flag_bits = '0;
					end
				end
			end
			SCAN_TOKENS: begin
				if (flags_left == 0) begin
					flag_bits = b;
					flags_left = 8;
				end else if (flag_bits[0]) begin
					hist_put(b);
					push_result(KIND_DATA, b, 32'h0, 1'b1);
					flag_bits = flag_bits >> 1;
					flags_left--;
				end else begin
					match_lo = b;
					scan = SCAN_MATCH_HI;
				end
			end
			SCAN_MATCH_HI: begin
				pos = {b[7:4], match_lo};
				cnt = int'(b[3:0]) + 3;
				for (int i = 0; i < cnt; i++) begin
					v = hist[pos];
					hist_put(v);
					pos = pos + 12'd1;
					push_result(KIND_DATA, v, 32'h0, i == cnt - 1);
				end
				flag_bits = flag_bits >> 1;
				flags_left--;
				scan = SCAN_TOKENS;
			end
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] exp_v,
	                               input logic [31:0] got_v);
		n_errors++;
		$display("%0t: %s: expected %0h, got %0h", $realtime, what, exp_v, got_v);
	endtask

	// Stimulus construction.
	task automatic put(input logic [7:0] b, input logic first = 1'b0,
	                   input logic drain = 1'b0);
		comp_item_t it;
		it.data = b;
		it.first = first;
		it.drain = drain;
		compressed_q.push_back(it);
		n_live++;
	endtask

	task automatic put_noise(input logic [7:0] b);
		put(b);
		n_live--;
	endtask

	task automatic put_literal(input logic [7:0] b);
		put(b);
		gen_wp = gen_wp + 12'd1;
		gen_out++;
	endtask

	task automatic send_header(input logic first, input int bad_at, input logic [31:0] len,
	                           input logic drain);
		logic [7:0] v;
		for (int i = 0; i < HDR_BYTES; i++) begin
			if (i < SIG_BYTES) begin
				v = SZDD_SIG[8*i +: 8];
				if (i == bad_at)
					v = v ^ 8'($urandom_range(1, 255));
			end else if (i < LEN_AT) begin
				v = 8'($urandom);
			end else begin
				v = len[8*(i-LEN_AT) +: 8];
			end
			put(v, first && i == 0, drain && i == 0);
			if (i == bad_at)
				return;
		end
		gen_wp = HIST_BASE;
		gen_out = 0;
	endtask

	task automatic put_match(input logic [11:0] pos, input logic [3:0] code);
		put(pos[7:0]);
		put({pos[11:8], code});
		gen_wp = gen_wp + 12'(code) + 12'd3;
		gen_out = gen_out + int'(code) + 3;
	endtask

	task automatic put_rand_match();
		logic [11:0] pos;
		int          reach;
		if (gen_out > 0 && $urandom_range(0, 3) != 0) begin
			reach = (gen_out < 200) ? gen_out : 200;
			pos = gen_wp - 12'($urandom_range(1, reach));
		end else begin
			pos = 12'($urandom);
		end
		put_match(pos, 4'($urandom));
	endtask

	task automatic send_tokens(input int groups, input bit cut);
		logic [7:0] ctrl;
		int         ntok;
		for (int g = 0; g < groups; g++) begin
			ctrl = 8'($urandom);
			case ($urandom_range(0, 2))
				1: ctrl = ctrl | 8'($urandom);
				2: ctrl = ctrl & 8'($urandom);
				default: ;
			endcase
			ntok = 8;
			if (g == groups - 1)
				ntok = cut ? $urandom_range(0, 7) : $urandom_range(1, 8);
			if (cut && g == groups - 1)
				ctrl[ntok] = 1'b0;
			put(ctrl);
			for (int t = 0; t < ntok; t++) begin
				if (ctrl[t])
					put_literal(8'($urandom));
				else
					put_rand_match();
			end
			if (cut && g == groups - 1 && $urandom_range(0, 1) == 1)
				put(8'($urandom));
		end
	endtask

	// Sender.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			tx_gap = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				decode_byte(s_tdata, s_tuser[0]);
				n_fed <= n_fed + 1;
				if ($urandom_range(0, 31) == 0)
					tx_steady = !tx_steady;
				tx_gap = tx_steady ? 0 : $urandom_range(0, 3);
			end else if (!s_tvalid && tx_gap > 0) begin
				tx_gap--;
			end
			if (s_tvalid && !s_tready) begin
				s_tvalid <= 1'b1;
			end else if (tx_gap == 0 && compressed_q.size() > 0 &&
			             !(compressed_q[0].drain && n_pred != n_checked)) begin
				s_tvalid <= 1'b1;
				s_tdata <= compressed_q[0].data;
				s_tuser <= compressed_q[0].first;
				void'(compressed_q.pop_front());
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver and checker.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_gap = 0;
			hold_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (decoded_fifo.size() == 0) begin
					report_mismatch("transfer with no result pending", 32'h0, m_tdata[31:0]);
				end else begin
					want = decoded_fifo.pop_front();
					n_checked <= n_checked + 1;
					if (m_tuser !== want.kind)
						report_mismatch("kind", 32'(want.kind), 32'(m_tuser));
					if (m_tdata[7:0] !== want.value)
						report_mismatch("out_byte", 32'(want.value), 32'(m_tdata[7:0]));
					if (m_tdata[39:8] !== want.length)
						report_mismatch("total_length", want.length, m_tdata[39:8]);
					if (m_tlast !== want.last)
						report_mismatch("tlast", 32'(want.last), 32'(m_tlast));
				end
				if ($urandom_range(0, 31) == 0)
					rx_steady = !rx_steady;
				rx_gap = rx_steady ? 0 : $urandom_range(0, 3);
			end else if (rx_gap > 0) begin
				rx_gap--;
			end
			if (hold_left > 0) begin
				hold_left--;
			end else if (!hold_done && n_fed >= 100 && s_tvalid) begin
				hold_left = RX_HOLD;
				hold_done = 1'b1;
			end
			m_tready <= (rx_gap == 0 && hold_left == 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == QUIET_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		int          n_total;
		int          sel;
		logic [31:0] len;
		n_pred = 0;
		n_fed = 0;
		n_checked = 0;
		n_errors = 0;
		n_live = 0;
		quiet_cycles = 0;
		hold_done = 1'b0;
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		restart_decoder();

		// First file arrives without a stream start mark.
		send_header(1'b0, -1, 32'hFFFF_FFFF, 1'b0);
		put(8'b0000_0011);
		put_literal(8'h00);
		put_literal(8'hFF);
		// Overlapping copy of the last byte, then a copy that begins in entries
		// never written and runs into written ones.
		put_match(gen_wp - 12'd1, 4'hF);
		put_match(12'hFE8, 4'hF);
		// Match cut off after its first byte.
		put(8'h5A);
		send_header(1'b1, 0, 32'h0, 1'b1);
		put_noise(8'($urandom));

		while (n_live < 245) begin
			sel = $urandom_range(0, 19);
			if (sel < 3) begin
				send_header(1'b1, $urandom_range(0, 8), 32'h0, $urandom_range(0, 3) == 0);
				repeat ($urandom_range(0, 3))
					put_noise(8'($urandom));
			end else begin
				len = (sel == 3) ? 32'h0 : (sel == 4) ? 32'hFFFF_FFFF : 32'($urandom);
				send_header(1'b1, -1, len, $urandom_range(0, 3) == 0);
				send_tokens($urandom_range(1, 5), sel >= 17);
			end
		end
		n_total = compressed_q.size();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (n_fed != n_total)
			@(negedge clk);
		while (decoded_fifo.size() != 0)
			@(negedge clk);
		repeat (60) @(negedge clk);

		if (n_errors == 0 && decoded_fifo.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
